### src/assert_macros.svh
// Assertion macros shared by the controller RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

### src/pgtg_pkg.sv
// Package for the polar go-to-goal controller: codes, constants, command type and helpers.
// Used by the controller, the datapath and the top level; depends on nothing.
package pgtg_pkg;

   localparam logic [1:0] CMD_TICK = 2'd0;
   localparam logic [1:0] CMD_POSE = 2'd1;
   localparam logic [1:0] CMD_GOAL = 2'd2;

   localparam logic [1:0] REG_REACH_RADIUS = 2'd0;
   localparam logic [1:0] REG_GAIN_RHO     = 2'd1;
   localparam logic [1:0] REG_GAIN_ALPHA   = 2'd2;
   localparam logic [1:0] REG_GAIN_BETA    = 2'd3;

   localparam logic [29:0]        INV_K_Q30   = 30'd652032874;
   localparam logic signed [31:0] PI_Q29      = 32'sd1686629713;
   localparam logic signed [15:0] HALF_PI_BAM = 16'sd16384;

   localparam logic [30:0]        RADIUS_RESET = 31'd6554;
   localparam logic signed [15:0] RHO_RESET    = 16'sd230;
   localparam logic signed [15:0] ALPHA_RESET  = 16'sd384;
   localparam logic signed [15:0] BETA_RESET   = -16'sd77;

   typedef struct packed {
      logic       pose_we;
      logic       push;
      logic       read;
      logic       init;
      logic       step;
      logic       mul;
      logic       rho;
      logic       ang;
      logic       prod;
      logic       wmul;
      logic       fin;
      logic [4:0] step_idx;
   } dp_cmd_type;

   function automatic logic [31:0] atan_lut(input logic [4:0] idx);
      logic [31:0] r;
      case (idx)
         5'd0:  r = 32'h20000000;
         5'd1:  r = 32'h12E4051E;
         5'd2:  r = 32'h09FB385B;
         5'd3:  r = 32'h051111D4;
         5'd4:  r = 32'h028B0D43;
         5'd5:  r = 32'h0145D7E1;
         5'd6:  r = 32'h00A2F61E;
         5'd7:  r = 32'h00517C55;
         5'd8:  r = 32'h0028BE53;
         5'd9:  r = 32'h00145F2F;
         5'd10: r = 32'h000A2F98;
         5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6;
         5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2FA;
         5'd15: r = 32'h0000517D;
         5'd16: r = 32'h000028BE;
         5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A30;
         5'd19: r = 32'h00000518;
         5'd20: r = 32'h0000028C;
         5'd21: r = 32'h00000146;
         5'd22: r = 32'h000000A3;
         5'd23: r = 32'h00000051;
         5'd24: r = 32'h00000029;
         5'd25: r = 32'h00000014;
         5'd26: r = 32'h0000000A;
         5'd27: r = 32'h00000005;
         5'd28: r = 32'h00000003;
         5'd29: r = 32'h00000001;
         5'd30: r = 32'h00000001;
         default: r = 32'h00000000;
      endcase
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sh000000007FFFFFFF) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -64'sh0000000080000000) begin
         r = -32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

### src/polar_go_to_goal_controller_top.sv
// Polar go-to-goal pose controller. A pose update or a goal push is taken while idle and
// gives no response; a full goal queue drops the goal and sets the sticky overflow flag. A
// control tick runs through the sequencer: READ, INIT, the iterative CORDIC (one micro-rotation
// per cycle, shared unit), the multiply stages and FIN, which waits for the result register
// to be free; the response turns valid and the request side is ready again in the same cycle.
// A finished response waits in its own register, so a new transaction may be accepted
// meanwhile. Configuration writes take effect at once and must be made while idle.
// Depends on pgtg_pkg, pgtg_ctrl and pgtg_dp.
module polar_go_to_goal_controller_top import pgtg_pkg::*; #(
   parameter int GOAL_DEPTH   = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_command,
   input  logic signed [31:0] req_in_x,
   input  logic signed [31:0] req_in_y,
   input  logic signed [15:0] req_in_yaw,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_lin_vel,
   output logic signed [31:0] rsp_ang_vel,
   output logic               rsp_goal_reached,
   output logic               rsp_no_goal,
   output logic [4:0]         rsp_goals_waiting,
   output logic               rsp_goal_overflow,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [30:0]        csr_wdata
);

   dp_cmd_type dp_cmd;

   pgtg_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .dp_cmd      (dp_cmd)
   );

   pgtg_dp #(.GOAL_DEPTH(GOAL_DEPTH)) u_dp (
      .clock             (clock),
      .reset             (reset),
      .dp_cmd            (dp_cmd),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_in_x          (req_in_x),
      .req_in_y          (req_in_y),
      .req_in_yaw        (req_in_yaw),
      .rsp_lin_vel       (rsp_lin_vel),
      .rsp_ang_vel       (rsp_ang_vel),
      .rsp_goal_reached  (rsp_goal_reached),
      .rsp_no_goal       (rsp_no_goal),
      .rsp_goals_waiting (rsp_goals_waiting),
      .rsp_goal_overflow (rsp_goal_overflow)
   );

endmodule

### src/pgtg_ctrl.sv
// Sequencer of the go-to-goal controller: handshakes and the datapath command per cycle.
// Depends on pgtg_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pgtg_ctrl import pgtg_pkg::*; #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_command,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output dp_cmd_type dp_cmd
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_READ, ST_INIT, ST_ITER, ST_MUL, ST_RHO, ST_ANG, ST_PROD, ST_WMUL, ST_FIN
   } state_type;

   localparam logic [4:0] LAST_STEP = 5'(CORDIC_STEPS - 1);

   state_type  state_ff;
   logic [4:0] step_ff;
   logic       rsp_valid_ff;
   logic       accept;
   logic       slot_free;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      dp_cmd          = '0;
      dp_cmd.step_idx = step_ff;
      dp_cmd.pose_we  = accept && (req_command == CMD_POSE);
      dp_cmd.push     = accept && (req_command == CMD_GOAL);
      dp_cmd.read     = (state_ff == ST_READ);
      dp_cmd.init     = (state_ff == ST_INIT);
      dp_cmd.step     = (state_ff == ST_ITER);
      dp_cmd.mul      = (state_ff == ST_MUL);
      dp_cmd.rho      = (state_ff == ST_RHO);
      dp_cmd.ang      = (state_ff == ST_ANG);
      dp_cmd.prod     = (state_ff == ST_PROD);
      dp_cmd.wmul     = (state_ff == ST_WMUL);
      dp_cmd.fin      = (state_ff == ST_FIN) && slot_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && !dp_cmd.fin) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept && (req_command == CMD_TICK)) begin
                  state_ff <= ST_READ;
               end
            end
            ST_READ: state_ff <= ST_INIT;
            ST_INIT: begin
               step_ff  <= '0;
               state_ff <= ST_ITER;
            end
            ST_ITER: begin
               step_ff <= step_ff + 5'd1;
               if (step_ff == LAST_STEP) begin
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL:  state_ff <= ST_RHO;
            ST_RHO:  state_ff <= ST_ANG;
            ST_ANG:  state_ff <= ST_PROD;
            ST_PROD: state_ff <= ST_WMUL;
            ST_WMUL: state_ff <= ST_FIN;
            ST_FIN: begin
               // The result register is loaded only once the previous transaction has left it.
               if (slot_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   `ASSERT_NEXT(a_tick_starts, clock, reset, accept && (req_command == CMD_TICK), state_ff == ST_READ)
   `ASSERT_NEXT(a_iter_ends, clock, reset, (state_ff == ST_ITER) && (step_ff == LAST_STEP), state_ff == ST_MUL)
   `ASSERT_NEXT(a_fin_gives_rsp, clock, reset, dp_cmd.fin, rsp_valid_ff)

endmodule

### src/pgtg_dp.sv
// Datapath of the go-to-goal controller: pose, goal queue, iterative CORDIC and gain products.
// Depends on pgtg_pkg and assert_macros.svh; driven cycle by cycle by pgtg_ctrl.
`include "assert_macros.svh"

module pgtg_dp import pgtg_pkg::*; #(
   parameter int GOAL_DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  dp_cmd_type         dp_cmd,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [30:0]        csr_wdata,
   input  logic signed [31:0] req_in_x,
   input  logic signed [31:0] req_in_y,
   input  logic signed [15:0] req_in_yaw,
   output logic signed [31:0] rsp_lin_vel,
   output logic signed [31:0] rsp_ang_vel,
   output logic               rsp_goal_reached,
   output logic               rsp_no_goal,
   output logic [4:0]         rsp_goals_waiting,
   output logic               rsp_goal_overflow
);

   localparam int IDX_W = (GOAL_DEPTH > 1) ? $clog2(GOAL_DEPTH) : 1;
   localparam int CNT_W = $clog2(GOAL_DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;

   // Configuration registers
   logic [30:0]        radius_ff;
   logic signed [15:0] gain_rho_ff, gain_alpha_ff, gain_beta_ff;

   // Pose and queue state
   logic signed [31:0] pose_x_ff, pose_y_ff;
   logic signed [15:0] pose_yaw_ff;
   logic [IDX_W-1:0]   head_ff, head_in, tail;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               ovf_ff;
   logic [79:0]        goal_mem [GOAL_DEPTH];
   logic [79:0]        goal_ff;
   logic               empty_ff;
   logic [SUM_W-1:0]   tail_sum;
   logic               full;

   // Working registers
   logic signed [35:0] x_ff, y_ff;
   logic [31:0]        z_ff;
   logic               zero_ff;
   logic [47:0]        plo_ff, phi_ff;
   logic [35:0]        rho_ff;
   logic signed [15:0] bam_ff, alpha_ff, beta_ff;
   logic signed [52:0] vprod_ff;
   logic signed [31:0] pa_ff, pb_ff;
   logic signed [53:0] v_ff;
   logic signed [64:0] wprod_ff;
   logic               reached_ff;

   // Output registers
   logic signed [31:0] out_v_ff, out_w_ff;
   logic               out_reached_ff, out_empty_ff, out_ovf_ff;
   logic [4:0]         out_wait_ff;

   // Combinational helpers
   logic signed [31:0] g_x, g_y;
   logic signed [15:0] g_yaw;
   logic signed [32:0] dx, dy;
   logic signed [35:0] xs, ys;
   logic [35:0]        ux;
   logic [66:0]        rsum;
   logic [31:0]        zr;
   logic signed [15:0] alpha_c, beta_c;
   logic signed [52:0] vsh;
   logic signed [32:0] wsum;
   logic signed [28:0] wsh;
   logic               pop;

   assign g_x   = goal_ff[79:48];
   assign g_y   = goal_ff[47:16];
   assign g_yaw = goal_ff[15:0];

   assign full     = (count_ff == CNT_W'(GOAL_DEPTH));
   assign tail_sum = SUM_W'(head_ff) + SUM_W'(count_ff);
   assign tail     = (tail_sum >= SUM_W'(GOAL_DEPTH)) ?
                     IDX_W'(tail_sum - SUM_W'(GOAL_DEPTH)) : IDX_W'(tail_sum);

   assign pop = dp_cmd.fin && reached_ff;

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (pop) begin
         head_in  = (head_ff == IDX_W'(GOAL_DEPTH - 1)) ? '0 : head_ff + IDX_W'(1);
         count_in = count_ff - CNT_W'(1);
      end else if (dp_cmd.push && !full) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   assign dx = $signed({g_x[31], g_x}) - $signed({pose_x_ff[31], pose_x_ff});
   assign dy = $signed({g_y[31], g_y}) - $signed({pose_y_ff[31], pose_y_ff});
   assign xs = x_ff >>> dp_cmd.step_idx;
   assign ys = y_ff >>> dp_cmd.step_idx;
   assign ux = x_ff[35] ? '0 : x_ff;
   assign rsum = ({19'b0, phi_ff} << 18) + {19'b0, plo_ff} + (67'd1 << 29);
   assign zr   = z_ff + 32'h00008000;

   assign alpha_c = bam_ff - pose_yaw_ff;
   assign beta_c  = g_yaw - pose_yaw_ff - alpha_c;
   assign vsh     = vprod_ff >>> 8;
   assign wsum    = 33'(pa_ff) + 33'(pb_ff);
   assign wsh     = 29'(wprod_ff >>> 36);

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff     <= RADIUS_RESET;
         gain_rho_ff   <= RHO_RESET;
         gain_alpha_ff <= ALPHA_RESET;
         gain_beta_ff  <= BETA_RESET;
         pose_x_ff     <= '0;
         pose_y_ff     <= '0;
         pose_yaw_ff   <= '0;
         head_ff       <= '0;
         count_ff      <= '0;
         ovf_ff        <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_REACH_RADIUS: radius_ff     <= csr_wdata;
               REG_GAIN_RHO:     gain_rho_ff   <= csr_wdata[15:0];
               REG_GAIN_ALPHA:   gain_alpha_ff <= csr_wdata[15:0];
               REG_GAIN_BETA:    gain_beta_ff  <= csr_wdata[15:0];
               default:          radius_ff     <= radius_ff;
            endcase
         end
         if (dp_cmd.pose_we) begin
            pose_x_ff   <= req_in_x;
            pose_y_ff   <= req_in_y;
            pose_yaw_ff <= req_in_yaw;
         end
         if (dp_cmd.push && full) begin
            ovf_ff <= 1'b1;
         end
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.push && !full) begin
         goal_mem[tail] <= {req_in_x, req_in_y, req_in_yaw};
      end
      if (dp_cmd.read) begin
         goal_ff  <= goal_mem[head_ff];
         empty_ff <= (count_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.init) begin
         zero_ff <= (dx == '0) && (dy == '0);
         // A vector in the left half-plane is turned through pi first.
         if (dx < 0) begin
            x_ff <= -36'(dx);
            y_ff <= -36'(dy);
            z_ff <= 32'h80000000;
         end else begin
            x_ff <= 36'(dx);
            y_ff <= 36'(dy);
            z_ff <= '0;
         end
      end
      if (dp_cmd.step) begin
         if (y_ff > 0) begin
            x_ff <= x_ff + ys;
            y_ff <= y_ff - xs;
            z_ff <= z_ff + atan_lut(dp_cmd.step_idx);
         end else begin
            x_ff <= x_ff - ys;
            y_ff <= y_ff + xs;
            z_ff <= z_ff - atan_lut(dp_cmd.step_idx);
         end
      end
      if (dp_cmd.mul) begin
         plo_ff <= 48'(ux[17:0]) * 48'(INV_K_Q30);
         phi_ff <= 48'(ux[35:18]) * 48'(INV_K_Q30);
      end
      if (dp_cmd.rho) begin
         rho_ff <= zero_ff ? '0 : rsum[65:30];
         bam_ff <= zero_ff ? '0 : zr[31:16];
      end
      if (dp_cmd.ang) begin
         alpha_ff   <= alpha_c;
         beta_ff    <= beta_c;
         vprod_ff   <= 53'(gain_rho_ff) * 53'($signed({1'b0, rho_ff}));
         reached_ff <= !empty_ff && (rho_ff < {5'b0, radius_ff});
      end
      if (dp_cmd.prod) begin
         pa_ff <= 32'(gain_alpha_ff) * 32'(alpha_ff);
         pb_ff <= 32'(gain_beta_ff) * 32'(beta_ff);
         if ((alpha_ff > HALF_PI_BAM) || (alpha_ff < -HALF_PI_BAM)) begin
            v_ff <= -54'(vsh);
         end else begin
            v_ff <= 54'(vsh);
         end
      end
      if (dp_cmd.wmul) begin
         wprod_ff <= 65'(wsum) * 65'(PI_Q29);
      end
      if (dp_cmd.fin) begin
         out_v_ff       <= empty_ff ? '0 : sat32(64'(v_ff));
         out_w_ff       <= empty_ff ? '0 : sat32(64'(wsh));
         out_reached_ff <= reached_ff;
         out_empty_ff   <= empty_ff;
         out_wait_ff    <= 5'(count_in);
         // The flag is captured with the transaction so that later goal pushes leave it alone.
         out_ovf_ff     <= ovf_ff;
      end
   end

   assign rsp_lin_vel       = out_v_ff;
   assign rsp_ang_vel       = out_w_ff;
   assign rsp_goal_reached  = out_reached_ff;
   assign rsp_no_goal       = out_empty_ff;
   assign rsp_goals_waiting = out_wait_ff;
   assign rsp_goal_overflow = out_ovf_ff;

   `ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(GOAL_DEPTH))
   `ASSERT_NEXT(a_pop_count, clock, reset, pop, count_ff == $past(count_ff) - CNT_W'(1))
   `ASSERT_IMPL(a_no_pop_empty, clock, reset, dp_cmd.fin && empty_ff, !reached_ff)

endmodule
